// ===== rtl/tdm_pkg.sv =====
// ----------------------------------------------------------------------------
// Transit duration meter package
// Shared constants and item types for the transit duration meter.
// ----------------------------------------------------------------------------
package tdm_pkg;

	// Sizes of the position index, the start queue and the time values.
	localparam int PosWidth   = 12;
	localparam int PosBits    = 12;
	localparam int QueueDepth = 64;
	localparam int ClockWidth = 48;
	localparam int IterWidth  = 32;
	localparam int StepWidth  = 32;
	localparam int QAddrWidth = $clog2(QueueDepth);
	localparam int QCntWidth  = $clog2(QueueDepth + 1);

	// Reset value of the last position register.
	localparam logic [PosWidth-1:0] LastPosReset = '1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NO_START = 2'd1;
	localparam logic [1:0] STATUS_DROPPED  = 2'd2;

	// One input item: an occupied position of the current iteration.
	typedef struct packed {
		logic [PosWidth-1:0]  position;
		logic                 position_valid;
		logic                 end_of_iteration;
		logic [StepWidth-1:0] time_step;
	} in_item_t;

	// One result item: a completed transit.
	typedef struct packed {
		logic [ClockWidth-1:0] duration;
		logic [IterWidth-1:0]  start_iteration;
		logic [IterWidth-1:0]  end_iteration;
		logic [1:0]            status;
	} out_item_t;

	// One entry of the start queue.
	typedef struct packed {
		logic [ClockWidth-1:0] start_clock;
		logic [IterWidth-1:0]  start_iter;
	} queue_entry_t;

	localparam int EntryWidth = $bits(queue_entry_t);

endpackage

// ===== rtl/transit_duration_meter_unit.sv =====
// ----------------------------------------------------------------------------
// Transit duration meter
// Measures the time occupants take to cross a track of positions.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on in_valid / in_stall / in_item, one per occupied
// position; the item with end_of_iteration set closes the iteration and
// carries its time step. A closing item in which the final position has just
// been vacated, while position zero has not just been entered, yields one
// result on out_valid / out_stall / out_item. All other items yield nothing.
// The last_position register is written through cfg_valid / cfg_ready /
// cfg_data; the user must write it only while the block is idle, as the
// block does not enforce this. cfg_ready is always high. Throughput is
// one item per cycle while in_stall is low. A result passes the registered
// read of the start queue RAM, then the duration subtract into the output
// register. When the receiver stalls, the output register holds its result
// and one more result can wait in the read stage; items that produce no
// result keep flowing. in_stall rises only when both stages hold results.
// Reset clears the clock, the iteration count, the flags and the queue
// pointers at once; queue contents are never read before being written.
// ----------------------------------------------------------------------------
module transit_duration_meter_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  tdm_pkg::in_item_t               in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output tdm_pkg::out_item_t              out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tdm_pkg::PosWidth-1:0]    cfg_data
);

	// Architectural state.
	logic [tdm_pkg::PosWidth-1:0]   last_pos_q;
	logic [tdm_pkg::ClockWidth-1:0] clock_q;
	logic [tdm_pkg::IterWidth-1:0]  iter_q;
	logic                           seen_first_q;
	logic                           seen_last_q;
	logic                           first_was_q;
	logic                           last_was_q;
	logic [tdm_pkg::QAddrWidth-1:0] rd_ptr_q;
	logic [tdm_pkg::QAddrWidth-1:0] wr_ptr_q;
	logic [tdm_pkg::QCntWidth-1:0]  count_q;
	logic                           dropped_q;

	// Read stage and output registers.
	logic                           valid_s1;
	logic                           empty_s1;
	logic [1:0]                     status_s1;
	logic [tdm_pkg::ClockWidth-1:0] clock_s1;
	logic [tdm_pkg::IterWidth-1:0]  end_iter_s1;
	logic                           out_valid_q;
	tdm_pkg::out_item_t             out_item_q;

	// Decode signals.
	logic                           accept;
	logic                           s1_move;
	logic                           seen_first_nx;
	logic                           seen_last_nx;
	logic [tdm_pkg::ClockWidth-1:0] clock_now;
	logic                           closing;
	logic                           active;
	logic                           rise;
	logic                           fall;
	logic                           q_full;
	logic                           q_empty;
	logic                           push;
	logic                           pop;
	tdm_pkg::queue_entry_t          wr_entry;
	tdm_pkg::queue_entry_t          rd_entry;
	logic [tdm_pkg::EntryWidth-1:0] rd_data;

	// Handshake: the read stage moves when the output register is free or taken.
	assign s1_move   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !s1_move;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Per-item flags and iteration close decisions.
	always_comb begin
		seen_first_nx = seen_first_q;
		seen_last_nx  = seen_last_q;
		if (in_item.position_valid) begin
			if (in_item.position[tdm_pkg::PosBits-1:0] == '0) begin
				seen_first_nx = 1'b1;
			end
			if (in_item.position[tdm_pkg::PosBits-1:0] ==
			    last_pos_q[tdm_pkg::PosBits-1:0]) begin
				seen_last_nx = 1'b1;
			end
		end
		clock_now = clock_q + {{(tdm_pkg::ClockWidth - tdm_pkg::StepWidth){1'b0}},
		                      in_item.time_step};
		closing   = accept && in_item.end_of_iteration;
		active    = closing && (iter_q != '0);
		rise      = !first_was_q && seen_first_nx;
		fall      = !rise && last_was_q && !seen_last_nx;
		q_full    = (count_q == tdm_pkg::QCntWidth'(tdm_pkg::QueueDepth));
		q_empty   = (count_q == '0);
		push      = active && rise && !q_full;
		pop       = active && fall && !q_empty;
	end

	assign wr_entry.start_clock = clock_now;
	assign wr_entry.start_iter  = iter_q;
	assign rd_entry             = tdm_pkg::queue_entry_t'(rd_data);

	// Start queue storage.
	tdm_ram #(
		.WIDTH (tdm_pkg::EntryWidth),
		.DEPTH (tdm_pkg::QueueDepth)
	) u_queue (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (wr_ptr_q),
		.wr_data (wr_entry),
		.rd_en   (pop),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= tdm_pkg::LastPosReset;
		end else if (cfg_valid && cfg_ready) begin
			last_pos_q <= cfg_data;
		end
	end

	// Clock, iteration count, flags and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q      <= '0;
			iter_q       <= '0;
			seen_first_q <= 1'b0;
			seen_last_q  <= 1'b0;
			first_was_q  <= 1'b0;
			last_was_q   <= 1'b0;
			rd_ptr_q     <= '0;
			wr_ptr_q     <= '0;
			count_q      <= '0;
			dropped_q    <= 1'b0;
		end else if (accept) begin
			if (in_item.end_of_iteration) begin
				clock_q      <= clock_now;
				iter_q       <= iter_q + 1'b1;
				seen_first_q <= 1'b0;
				seen_last_q  <= 1'b0;
				if (active) begin
					first_was_q <= seen_first_nx;
					last_was_q  <= seen_last_nx;
				end
				if (active && rise && q_full) begin
					dropped_q <= 1'b1;
				end
				if (push) begin
					wr_ptr_q <= (wr_ptr_q == tdm_pkg::QAddrWidth'(tdm_pkg::QueueDepth - 1))
						? '0 : wr_ptr_q + 1'b1;
					count_q  <= count_q + 1'b1;
				end
				if (pop) begin
					rd_ptr_q <= (rd_ptr_q == tdm_pkg::QAddrWidth'(tdm_pkg::QueueDepth - 1))
						? '0 : rd_ptr_q + 1'b1;
					count_q  <= count_q - 1'b1;
				end
			end else begin
				seen_first_q <= seen_first_nx;
				seen_last_q  <= seen_last_nx;
			end
		end
	end

	// Read stage: holds the result context while the queue RAM is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= active && fall;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			empty_s1    <= q_empty;
			status_s1   <= q_empty ? tdm_pkg::STATUS_NO_START
				: (dropped_q ? tdm_pkg::STATUS_DROPPED : tdm_pkg::STATUS_OK);
			clock_s1    <= clock_q;
			end_iter_s1 <= iter_q - 1'b1;
		end
	end

	// Output register: duration is the clock before exit minus the entry clock.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && valid_s1) begin
			out_item_q.duration        <= empty_s1 ? '0 : clock_s1 - rd_entry.start_clock;
			out_item_q.start_iteration <= empty_s1 ? '0 : rd_entry.start_iter;
			out_item_q.end_iteration   <= end_iter_s1;
			out_item_q.status          <= status_s1;
		end
	end

endmodule

// ===== rtl/tdm_ram.sv =====
// ----------------------------------------------------------------------------
// Transit duration meter RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tdm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== tb/sv/tdm_transit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transit duration checker
// Watches the item, result and register channels of the transit duration
// meter. It follows every accepted item with its own copy of the clock, the
// iteration count, the occupancy flags and the start queue. It then compares
// each accepted result, field by field, with the oldest predicted transit.
// ----------------------------------------------------------------------------
module tdm_transit_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  tdm_pkg::in_item_t            in_item,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  tdm_pkg::out_item_t           out_item,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [tdm_pkg::PosWidth-1:0] cfg_data,
	output int                           fail_count,
	output int                           pending,
	output int                           transit_count,
	output int                           no_start_count,
	output int                           after_drop_count
);
	import tdm_pkg::*;

	localparam int ReportLimit = 10;

	// Predicted state of the meter.
	logic [PosWidth-1:0]   final_pos;
	logic [ClockWidth-1:0] clock_sum;
	logic [IterWidth-1:0]  iter_num;
	logic                  first_now;
	logic                  final_now;
	logic                  first_prev;
	logic                  final_prev;
	logic                  starts_lost;
	queue_entry_t          start_fifo[$];

	// Transits that are predicted but not yet seen on the result channel.
	out_item_t             due_transits[$];
	int                    fails;
	int                    checked;
	int                    no_start_seen;
	int                    after_drop_seen;

	// Follow one accepted item; a closing item may predict one transit.
	task automatic follow_item(input in_item_t it);
		logic [ClockWidth-1:0] clock_now;
		logic [PosBits-1:0]    pos_low;
		queue_entry_t          entry;
		out_item_t             transit;
		pos_low = it.position[PosBits-1:0];
		if (it.position_valid) begin
			if (pos_low == '0)
				first_now = 1'b1;
			if (pos_low == final_pos[PosBits-1:0])
				final_now = 1'b1;
		end
		if (it.end_of_iteration) begin
			clock_now = clock_sum + ClockWidth'(it.time_step);
			// Iteration zero only moves the clock and the count.
			if (iter_num != '0) begin
				if (!first_prev && first_now) begin
					if (start_fifo.size() < QueueDepth) begin
						entry.start_clock = clock_now;
						entry.start_iter  = iter_num;
						start_fifo = {start_fifo, entry};
					end else begin
						starts_lost = 1'b1;
					end
				end else if (final_prev && !final_now) begin
					transit.end_iteration = iter_num - 1'b1;
					if (start_fifo.size() == 0) begin
						transit.duration        = '0;
						transit.start_iteration = '0;
						transit.status          = STATUS_NO_START;
					end else begin
						entry = start_fifo[0];
						start_fifo.delete(0);
						transit.duration        = clock_sum - entry.start_clock;
						transit.start_iteration = entry.start_iter;
						transit.status          = starts_lost ? STATUS_DROPPED : STATUS_OK;
					end
					due_transits = {due_transits, transit};
				end
				first_prev = first_now;
				final_prev = final_now;
			end
			clock_sum = clock_now;
			iter_num  = iter_num + 1'b1;
			first_now = 1'b0;
			final_now = 1'b0;
		end
	endtask

	// Compare one accepted result with the oldest predicted transit.
	task automatic check_transit(input out_item_t got);
		out_item_t want;
		if (due_transits.size() == 0) begin
			fails++;
			if (fails <= ReportLimit)
				$display("%0t: unexpected result dur=%h start=%0d end=%0d status=%0d",
					$realtime, got.duration, got.start_iteration, got.end_iteration,
					got.status);
		end else begin
			want = due_transits[0];
			due_transits.delete(0);
			checked++;
			if (want.status == STATUS_NO_START)
				no_start_seen++;
			if (want.status == STATUS_DROPPED)
				after_drop_seen++;
			if (got.duration !== want.duration ||
					got.start_iteration !== want.start_iteration ||
					got.end_iteration !== want.end_iteration ||
					got.status !== want.status) begin
				fails++;
				if (fails <= ReportLimit) begin
					$display("%0t: transit mismatch: expected dur=%h start=%0d end=%0d status=%0d",
						$realtime, want.duration, want.start_iteration,
						want.end_iteration, want.status);
					$display("%0t: transit mismatch: got      dur=%h start=%0d end=%0d status=%0d",
						$realtime, got.duration, got.start_iteration,
						got.end_iteration, got.status);
				end
			end
		end
	endtask

	// Results are checked before new items are followed; a result can never
	// belong to an item accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			final_pos  = LastPosReset;
			clock_sum  = '0;
			iter_num   = '0;
			first_now  = 1'b0;
			final_now  = 1'b0;
			first_prev = 1'b0;
			final_prev = 1'b0;
			starts_lost = 1'b0;
			start_fifo.delete();
			due_transits.delete();
			fails           = 0;
			checked         = 0;
			no_start_seen   = 0;
			after_drop_seen = 0;
			fail_count       <= 0;
			pending          <= 0;
			transit_count    <= 0;
			no_start_count   <= 0;
			after_drop_count <= 0;
		end else begin
			if (out_valid && !out_stall)
				check_transit(out_item);
			if (in_valid && !in_stall)
				follow_item(in_item);
			if (cfg_valid && cfg_ready)
				final_pos = cfg_data;
			fail_count       <= fails;
			pending          <= due_transits.size();
			transit_count    <= checked;
			no_start_count   <= no_start_seen;
			after_drop_count <= after_drop_seen;
		end
	end

endmodule

// ===== tb/sv/transit_duration_meter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Transit duration meter testbench
// Drives iterations of occupied positions into the meter. There is a short
// directed part first. Then come randomized occupants crossing tracks of
// several lengths, a start queue overflow and a long transit with large time
// steps. Both channels idle in random bursts. A checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------
module transit_duration_meter_unit_tb;
	import tdm_pkg::*;

	localparam int CycleLimit     = 2_000_000;
	localparam int DrainCycles    = 4;
	localparam int LongIterations = 40;
	localparam int OverflowStarts = 70;
	localparam int PosMax         = (1 << PosWidth) - 1;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	in_item_t            in_item;
	logic                out_valid;
	logic                out_stall;
	out_item_t           out_item;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [PosWidth-1:0] cfg_data;

	int fail_count;
	int pending;
	int transit_count;
	int no_start_count;
	int after_drop_count;

	bit idle_on;
	int items_sent;
	int cfg_writes;
	int cycles;
	int crossing[$];

	transit_duration_meter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	tdm_transit_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.in_item          (in_item),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_item         (out_item),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.fail_count       (fail_count),
		.pending          (pending),
		.transit_count    (transit_count),
		.no_start_count   (no_start_count),
		.after_drop_count (after_drop_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// The receiver stalls in random bursts while idling is enabled.
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 11) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Time steps: small fractions, typical Q16.16 values, or anything.
	function automatic logic [StepWidth-1:0] pick_step();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 32'h0000_FFFF);
			1: return $urandom_range(32'h0001_0000, 32'h0010_0000);
			default: return $urandom();
		endcase
	endfunction

	// Offer one item, with an optional random gap first, and wait for it.
	task automatic send_item(input int pos, input logic pos_ok,
			input logic closes, input logic [StepWidth-1:0] step);
		in_item_t it;
		it.position         = PosWidth'(pos);
		it.position_valid   = pos_ok;
		it.end_of_iteration = closes;
		it.time_step        = step;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Stray items: mostly unmarked positions, now and then a stray occupant.
	task automatic send_noise();
		if ($urandom_range(0, 39) == 0)
			send_item($urandom_range(0, PosMax), 1'b1, 1'b0, $urandom());
		else
			send_item($urandom_range(0, PosMax), 1'b0, 1'b0, $urandom());
	endtask

	// Send one iteration holding the positions in crossing, in a rotated
	// order. It closes on the last occupant or on an unmarked extra item.
	task automatic send_iteration();
		logic [StepWidth-1:0] step;
		bit                   tail_closes;
		bit                   closes;
		int                   n;
		int                   k0;
		step        = pick_step();
		n           = crossing.size();
		tail_closes = (n != 0) && ($urandom_range(0, 1) == 1);
		k0          = (n != 0) ? $urandom_range(0, n - 1) : 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 5) == 0)
				send_noise();
			closes = tail_closes && (i == n - 1);
			send_item(crossing[(i + k0) % n], 1'b1, closes, closes ? step : $urandom());
		end
		if (!tail_closes)
			send_item($urandom_range(0, PosMax), 1'b0, 1'b1, step);
	endtask

	// Occupants advance by random strides, leave past the final position,
	// and new ones enter at position zero.
	task automatic move_occupants(input int final_pos, input int span);
		int moved[$];
		int next_pos;
		foreach (crossing[i]) begin
			next_pos = crossing[i];
			if ($urandom_range(0, 3) != 0)
				next_pos += $urandom_range(1, span);
			if (next_pos <= final_pos)
				moved = {moved, next_pos};
		end
		if ($urandom_range(0, 2) == 0)
			moved = {moved, 0};
		crossing = moved;
	endtask

	task automatic run_track(input int final_pos, input int span, input int budget);
		int stop_at;
		stop_at = items_sent + budget;
		crossing.delete();
		while (items_sent < stop_at) begin
			move_occupants(final_pos, span);
			send_iteration();
		end
	endtask

	// Stop offering items and wait until every predicted transit is out.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_final_position(input int value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= PosWidth'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	initial begin
		int lp;
		in_valid  <= 1'b0;
		in_item   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		idle_on = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the final position at its reset value.
		idle_on = 1'b1;
		// Iteration zero only advances the clock, even with position zero set.
		send_item(0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item(PosMax, 1'b1, 1'b1, 32'h0000_0001);
		// Unmarked position zero; the final position is vacated with an
		// empty start queue.
		send_item(0, 1'b0, 1'b1, 32'h0001_0000);
		send_item(PosMax, 1'b1, 1'b1, 32'h0000_0000);
		// First rises while the final position falls: only the start counts.
		send_item(1234, 1'b0, 1'b0, $urandom());
		send_item(0, 1'b1, 1'b1, 32'h0002_8000);
		send_item(PosMax, 1'b1, 1'b0, $urandom());
		send_item(0, 1'b1, 1'b1, 32'hFFFF_FFFF);
		send_item(0, 1'b0, 1'b1, 32'h0000_8000);
		send_item(0, 1'b1, 1'b1, 32'h0000_0001);
		send_item(2048, 1'b1, 1'b1, 32'h8000_0000);
		send_item(PosMax, 1'b1, 1'b1, 32'h7FFF_FFFF);
		send_item(PosMax - 1, 1'b1, 1'b1, 32'h1234_5678);

		// Tracks of several lengths, the extremes among them.
		write_final_position(0);
		run_track(0, 1, 100);
		lp = $urandom_range(1, 15);
		write_final_position(lp);
		run_track(lp, 2, 150);
		idle_on = 1'b0;
		write_final_position(PosMax);
		run_track(PosMax, 700, 100);
		idle_on = 1'b1;
		lp = $urandom_range(16, PosMax - 1);
		write_final_position(lp);
		run_track(lp, lp / 5 + 1, 120);

		// Overflow the start queue, then drain it past empty.
		lp = $urandom_range(1, PosMax);
		write_final_position(lp);
		repeat (OverflowStarts) begin
			crossing = {0};
			send_iteration();
			crossing.delete();
			send_iteration();
		end
		repeat (OverflowStarts + 2) begin
			crossing = {lp};
			send_iteration();
			crossing.delete();
			send_iteration();
		end

		// Last part without idling: a long transit with the largest steps.
		idle_on = 1'b0;
		crossing = {0};
		send_iteration();
		repeat (LongIterations)
			send_item($urandom_range(0, PosMax), 1'b0, 1'b1, 32'hFFFF_FFFF);
		crossing = {lp};
		send_iteration();
		crossing.delete();
		send_iteration();
		lp = $urandom_range(1, 31);
		write_final_position(lp);
		run_track(lp, 3, 100);

		settle();
		$display("Sent %0d items and %0d register writes, including a queue overflow.",
			items_sent, cfg_writes);
		$display("Checked %0d transits (%0d without a start, %0d after drops), %0d failures.",
			transit_count, no_start_count, after_drop_count, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== transit_duration_meter_unit.f =====
rtl/tdm_pkg.sv
rtl/tdm_ram.sv
rtl/transit_duration_meter_unit.sv
tb/sv/tdm_transit_checker.sv
tb/sv/transit_duration_meter_unit_tb.sv
